/* design/tdpr_pkg.sv */
`timescale 1ns / 1ps

package tdpr_pkg;

  // Default field widths
  localparam int COORD_BITS_DEF = 16;
  localparam int ID_BITS_DEF    = 8;

  // Fixed field widths
  localparam int TIME_BITS     = 32;
  localparam int RADIUS_BITS   = 32;
  localparam int LONG_TAP_BITS = 16;
  localparam int OP_BITS       = 2;
  localparam int GEST_BITS     = 4;
  localparam int OUT_USER_BITS = GEST_BITS + 1;

  // Configuration port
  localparam int CFG_IDX_BITS  = 2;
  localparam int CFG_DATA_BITS = 32;

  localparam logic [CFG_IDX_BITS-1:0] CFG_DRAG_RADIUS_SQ = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_LONG_TAP_MS    = 2'd1;

  localparam logic [RADIUS_BITS-1:0]   DRAG_RADIUS_SQ_RST = 32'd4;
  localparam logic [LONG_TAP_BITS-1:0] LONG_TAP_MS_RST    = 16'd500;

  // Touch event kinds
  localparam logic [OP_BITS-1:0] OP_BEGAN = 2'd0;
  localparam logic [OP_BITS-1:0] OP_MOVED = 2'd1;
  localparam logic [OP_BITS-1:0] OP_ENDED = 2'd2;

  // Gesture codes reported with each event
  typedef enum logic [GEST_BITS-1:0] {
    G_NONE        = 4'd0,
    G_TAP         = 4'd1,
    G_LONG_TAP    = 4'd2,
    G_DRAG_BEGIN  = 4'd3,
    G_DRAG_CONT   = 4'd4,
    G_DRAG_END    = 4'd5,
    G_PINCH_BEGIN = 4'd6,
    G_PINCH_CONT  = 4'd7,
    G_PINCH_END   = 4'd8
  } gesture_e;

endpackage

/* design/tap_drag_pinch_recognizer_unit.sv */
`timescale 1ns / 1ps
// Channel   | Direction | Handshake                     | Payload
// s_axis    | in        | s_axis_tvalid_i/tready_o      | tuser op; tdata id, x, y, now_ms
// m_axis    | out       | m_axis_tvalid_o/tready_i      | tuser gesture, accepted; tdata points
// cfg       | in        | cfg_valid_i/cfg_ready_o       | cfg_index_i, cfg_data_i
//
// One event per cycle while the result side does not stall; a request passes
// through the input register and then the result register. The state update and
// squared-distance compare sit between them and feed the state registers directly.
// Reset clears the gesture state, both points, the start time and the configuration
// registers to their defaults; no clearing pass is needed.
// A stalled result holds in the result register; the input register keeps
// taking events until it is also full.

module tap_drag_pinch_recognizer_unit #(
  parameter int COORD_BITS = tdpr_pkg::COORD_BITS_DEF,
  parameter int ID_BITS    = tdpr_pkg::ID_BITS_DEF,
  localparam int IN_RAW    = ID_BITS + 2 * COORD_BITS + tdpr_pkg::TIME_BITS,
  localparam int IN_W      = ((IN_RAW + 7) / 8) * 8,
  localparam int PT_RAW    = 2 * COORD_BITS + ID_BITS + tdpr_pkg::TIME_BITS,
  localparam int OUT_RAW   = 2 * PT_RAW,
  localparam int OUT_W     = ((OUT_RAW + 7) / 8) * 8
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 s_axis_tvalid_i,
  output logic                                 s_axis_tready_o,
  // tdata: touch_id, touch_x, touch_y, now_ms, zero fill
  input  logic [IN_W-1:0]                      s_axis_tdata_i,
  // tuser: op
  input  logic [tdpr_pkg::OP_BITS-1:0]         s_axis_tuser_i,
  output logic                                 m_axis_tvalid_o,
  input  logic                                 m_axis_tready_i,
  // tdata: first_x, first_y, first_id, first_time,
  //        second_x, second_y, second_id, second_time, zero fill
  output logic [OUT_W-1:0]                     m_axis_tdata_o,
  // tuser: gesture, accepted
  output logic [tdpr_pkg::OUT_USER_BITS-1:0]   m_axis_tuser_o,
  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  logic [tdpr_pkg::CFG_IDX_BITS-1:0]    cfg_index_i,
  input  logic [tdpr_pkg::CFG_DATA_BITS-1:0]   cfg_data_i
);
  import tdpr_pkg::*;

  localparam int C = COORD_BITS;
  localparam int T = TIME_BITS;

  // Gesture machine states
  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_DOWN  = 2'd1;
  localparam logic [1:0] ST_DRAG  = 2'd2;
  localparam logic [1:0] ST_PINCH = 2'd3;

  // Configuration registers
  logic [RADIUS_BITS-1:0]   radius_q;
  logic [LONG_TAP_BITS-1:0] long_q;

  // Input register
  logic                in_valid_q;
  logic [OP_BITS-1:0]  op_q;
  logic [ID_BITS-1:0]  id_q;
  logic signed [C-1:0] x_q, y_q;
  logic [T-1:0]        now_q;

  // Gesture state
  logic [1:0]          st_q, st_d;
  logic [T-1:0]        start_q, start_d;
  logic signed [C-1:0] px_q [2];
  logic signed [C-1:0] py_q [2];
  logic [ID_BITS-1:0]  pid_q [2];
  logic [T-1:0]        pt_q [2];
  logic signed [C-1:0] px_d [2];
  logic signed [C-1:0] py_d [2];
  logic [ID_BITS-1:0]  pid_d [2];
  logic [T-1:0]        pt_d [2];

  // Result register
  logic                out_valid_q;
  logic [OUT_W-1:0]    out_data_q;
  logic [OUT_USER_BITS-1:0] out_user_q;

  logic       advance;
  logic       far;
  logic       keep0, keep1;
  logic       m0, m1;
  logic [T-1:0] rel_time, held;
  gesture_e   gest;
  logic       acc;
  logic [OUT_RAW-1:0] res_raw;

  assign advance         = in_valid_q && (!out_valid_q || m_axis_tready_i);
  assign s_axis_tready_o = !in_valid_q || advance;
  assign cfg_ready_o     = 1'b1;

  // Write configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radius_q <= DRAG_RADIUS_SQ_RST;
      long_q   <= LONG_TAP_MS_RST;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_DRAG_RADIUS_SQ: radius_q <= RADIUS_BITS'(cfg_data_i);
        CFG_LONG_TAP_MS:    long_q   <= cfg_data_i[LONG_TAP_BITS-1:0];
        default: ;
      endcase
    end
  end

  // Capture the incoming request
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready_o) begin
      in_valid_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid_i && s_axis_tready_o) begin
      op_q  <= s_axis_tuser_i;
      id_q  <= s_axis_tdata_i[ID_BITS-1:0];
      x_q   <= s_axis_tdata_i[ID_BITS +: C];
      y_q   <= s_axis_tdata_i[ID_BITS + C +: C];
      now_q <= s_axis_tdata_i[ID_BITS + 2 * C +: T];
    end
  end

  tdpr_dist #(
    .COORD_BITS (COORD_BITS)
  ) u_dist (
    .x_i         (x_q),
    .y_i         (y_q),
    .ref_x_i     (px_q[0]),
    .ref_y_i     (py_q[0]),
    .radius_sq_i (radius_q),
    .far_o       (far)
  );

  assign m0       = (pid_q[0] == id_q);
  assign m1       = (pid_q[1] == id_q);
  assign held     = now_q - start_q;
  // A fresh gesture starts its clock at this event
  assign rel_time = (st_q == ST_IDLE && op_q == OP_BEGAN) ? '0 : held;

  // Decide the next state and the gesture code
  always_comb begin
    st_d    = st_q;
    start_d = start_q;
    gest    = G_NONE;
    acc     = 1'b1;
    keep0   = 1'b0;
    keep1   = 1'b0;
    case (op_q)
      OP_BEGAN: begin
        case (st_q)
          ST_IDLE: begin
            start_d = now_q;
            keep0   = 1'b1;
            st_d    = ST_DOWN;
          end
          ST_DOWN: begin
            keep1 = 1'b1;
            st_d  = ST_PINCH;
            gest  = G_PINCH_BEGIN;
          end
          default: acc = 1'b0;
        endcase
      end
      OP_MOVED: begin
        case (st_q)
          ST_DRAG: begin
            if (m1) begin
              keep1 = 1'b1;
              gest  = G_DRAG_CONT;
            end
          end
          ST_DOWN: begin
            if (!m0) begin
              st_d = ST_IDLE;
            end else if (far) begin
              keep1 = 1'b1;
              st_d  = ST_DRAG;
              gest  = G_DRAG_BEGIN;
            end
          end
          ST_PINCH: begin
            keep0 = m0;
            keep1 = m1;
            gest  = G_PINCH_CONT;
          end
          default: ;
        endcase
      end
      OP_ENDED: begin
        case (st_q)
          ST_DRAG: begin
            if (m1) begin
              keep1 = 1'b1;
              st_d  = ST_IDLE;
              gest  = G_DRAG_END;
            end
          end
          ST_DOWN: begin
            keep0 = 1'b1;
            st_d  = ST_IDLE;
            gest  = (held > T'(long_q)) ? G_LONG_TAP : G_TAP;
          end
          ST_PINCH: begin
            keep0 = m0;
            keep1 = m1;
            st_d  = ST_IDLE;
            gest  = G_PINCH_END;
          end
          default: ;
        endcase
      end
      default: acc = 1'b0;
    endcase
  end

  // Load the touched points
  always_comb begin
    px_d[0]  = keep0 ? x_q      : px_q[0];
    py_d[0]  = keep0 ? y_q      : py_q[0];
    pid_d[0] = keep0 ? id_q     : pid_q[0];
    pt_d[0]  = keep0 ? rel_time : pt_q[0];
    px_d[1]  = keep1 ? x_q      : px_q[1];
    py_d[1]  = keep1 ? y_q      : py_q[1];
    pid_d[1] = keep1 ? id_q     : pid_q[1];
    pt_d[1]  = keep1 ? rel_time : pt_q[1];
  end

  // Advance the gesture state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q    <= ST_IDLE;
      start_q <= '0;
      px_q    <= '{default: '0};
      py_q    <= '{default: '0};
      pid_q   <= '{default: '0};
      pt_q    <= '{default: '0};
    end else if (advance) begin
      st_q    <= st_d;
      start_q <= start_d;
      px_q    <= px_d;
      py_q    <= py_d;
      pid_q   <= pid_d;
      pt_q    <= pt_d;
    end
  end

  assign res_raw = {pt_d[1], pid_d[1], py_d[1], px_d[1],
                    pt_d[0], pid_d[0], py_d[0], px_d[0]};

  // Hold the result until it is taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_data_q <= OUT_W'(res_raw);
      out_user_q <= {acc, gest};
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;
  assign m_axis_tuser_o  = out_user_q;

  // A drag begin always leaves the machine in drag
  a_drag_begin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && gest == G_DRAG_BEGIN) |=> (st_q == ST_DRAG))
    else $error("drag begin did not enter drag");

  // Taps and gesture ends return to idle
  a_end_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && (gest == G_TAP || gest == G_LONG_TAP || gest == G_DRAG_END ||
                 gest == G_PINCH_END)) |=> (st_q == ST_IDLE))
    else $error("gesture end did not return to idle");

  // A rejected began only happens during drag or pinch
  a_reject: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && op_q == OP_BEGAN && !acc) |-> (st_q == ST_DRAG || st_q == ST_PINCH))
    else $error("began rejected outside drag or pinch");

  // A waiting request stays put while the result side stalls
  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_q && !advance) |=> (in_valid_q && $stable(op_q) && $stable(now_q)))
    else $error("input register lost a stalled request");

endmodule

/* design/tdpr_dist.sv */
`timescale 1ns / 1ps

module tdpr_dist #(
  parameter int COORD_BITS = tdpr_pkg::COORD_BITS_DEF
) (
  input  logic signed [COORD_BITS-1:0]        x_i,
  input  logic signed [COORD_BITS-1:0]        y_i,
  input  logic signed [COORD_BITS-1:0]        ref_x_i,
  input  logic signed [COORD_BITS-1:0]        ref_y_i,
  input  logic        [tdpr_pkg::RADIUS_BITS-1:0] radius_sq_i,
  output logic                                far_o
);
  import tdpr_pkg::*;

  localparam int DW = COORD_BITS + 1;
  localparam int QW = 2 * DW;
  localparam int SW = QW + 1;
  localparam int CW = (SW > RADIUS_BITS) ? SW : RADIUS_BITS;

  logic signed [DW-1:0] dx, dy;
  logic        [DW-1:0] ax, ay;
  logic        [QW-1:0] sx, sy;
  logic        [SW-1:0] sum;
  logic        [CW-1:0] sum_w, rad_w;

  // Take absolute differences against the first point
  assign dx = DW'(x_i) - DW'(ref_x_i);
  assign dy = DW'(y_i) - DW'(ref_y_i);
  assign ax = dx[DW-1] ? DW'(-dx) : DW'(dx);
  assign ay = dy[DW-1] ? DW'(-dy) : DW'(dy);

  // Exact squared distance, compared at a common width
  assign sx    = QW'(ax) * QW'(ax);
  assign sy    = QW'(ay) * QW'(ay);
  assign sum   = SW'(sx) + SW'(sy);
  assign sum_w = CW'(sum);
  assign rad_w = CW'(radius_sq_i);
  assign far_o = (sum_w >= rad_w);

endmodule
